### rtl/sefd_pkg.sv
package sefd_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned SevenWidth = 7;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned RspDataWidth = 48;

   localparam logic [CsrIndexWidth-1:0] REG_START_CODE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_END_CODE = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_SECURE_OPCODE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_PLAIN_LOW = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_PLAIN_HIGH = 3'd4;

   localparam logic [ByteWidth-1:0] START_CODE_RESET = 8'd2;
   localparam logic [ByteWidth-1:0] END_CODE_RESET = 8'd3;
   localparam logic [ByteWidth-1:0] SECURE_OPCODE_RESET = 8'd181;
   localparam logic [ByteWidth-1:0] PLAIN_LOW_RESET = 8'd128;
   localparam logic [ByteWidth-1:0] PLAIN_HIGH_RESET = 8'd182;

   localparam logic [StatusWidth-1:0] STATUS_OK = 3'd0;
   localparam logic [StatusWidth-1:0] STATUS_BAD_CHECKSUM = 3'd1;
   localparam logic [StatusWidth-1:0] STATUS_TOO_SHORT = 3'd2;
   localparam logic [StatusWidth-1:0] STATUS_TOO_LONG = 3'd3;
   localparam logic [StatusWidth-1:0] STATUS_SECURE = 3'd4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [ByteWidth-1:0] CHECKSUM_TOP_BIT = 8'h80;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR0,
      PH_ADDR1,
      PH_ADDR2,
      PH_OPCODE,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] start_code;
      logic [ByteWidth-1:0] end_code;
      logic [ByteWidth-1:0] secure_opcode;
      logic [ByteWidth-1:0] plain_opcode_low;
      logic [ByteWidth-1:0] plain_opcode_high;
   } cfg_type;

   typedef struct packed {
      logic                   out_kind;
      logic [SevenWidth-1:0]  payload_byte;
      logic [SevenWidth-1:0]  addr_first;
      logic [SevenWidth-1:0]  addr_second;
      logic [SevenWidth-1:0]  addr_third;
      logic [ByteWidth-1:0]   frame_opcode;
      logic [ByteWidth-1:0]   payload_count;
      logic [StatusWidth-1:0] frame_status;
   } result_type;

endpackage

### rtl/sefd_csr.sv
module sefd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sefd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [sefd_pkg::ByteWidth-1:0]      csr_wdata,
   output sefd_pkg::cfg_type                   cfg
);
   import sefd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_CODE:    cfg_in.start_code = csr_wdata;
            REG_END_CODE:      cfg_in.end_code = csr_wdata;
            REG_SECURE_OPCODE: cfg_in.secure_opcode = csr_wdata;
            REG_PLAIN_LOW:     cfg_in.plain_opcode_low = csr_wdata;
            REG_PLAIN_HIGH:    cfg_in.plain_opcode_high = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code <= START_CODE_RESET;
         cfg_ff.end_code <= END_CODE_RESET;
         cfg_ff.secure_opcode <= SECURE_OPCODE_RESET;
         cfg_ff.plain_opcode_low <= PLAIN_LOW_RESET;
         cfg_ff.plain_opcode_high <= PLAIN_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/sefd_core.sv
module sefd_core #(
   parameter int unsigned MAX_PAYLOAD = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sefd_pkg::cfg_type               cfg,
   input  logic                            take,
   input  logic [sefd_pkg::ByteWidth-1:0]  rx_byte,
   output logic                            result_valid,
   output sefd_pkg::result_type            result
);
   import sefd_pkg::*;

   // counter is 8 bits wide, so the limit caps at 255
   localparam logic [ByteWidth-1:0] CountLimit =
      (MAX_PAYLOAD > 255) ? 8'd255 : ByteWidth'(MAX_PAYLOAD);

   phase_type              phase_ff, phase_in;
   logic [ByteWidth-1:0]   xor_ff, xor_in;
   logic [ByteWidth-1:0]   held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;
   logic [SevenWidth-1:0]  addr0_ff, addr0_in;
   logic [SevenWidth-1:0]  addr1_ff, addr1_in;
   logic [SevenWidth-1:0]  addr2_ff, addr2_in;
   logic [ByteWidth-1:0]   opcode_ff, opcode_in;
   logic [ByteWidth-1:0]   count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   plain;
   logic [ByteWidth-1:0]   expected_sum;

   assign plain = (opcode_ff >= cfg.plain_opcode_low) &&
                  (opcode_ff <= cfg.plain_opcode_high) &&
                  (opcode_ff != cfg.secure_opcode);
   assign expected_sum = ~xor_ff | CHECKSUM_TOP_BIT;

   always_comb begin
      phase_in = phase_ff;
      xor_in = xor_ff;
      held_in = held_ff;
      held_valid_in = held_valid_ff;
      addr0_in = addr0_ff;
      addr1_in = addr1_ff;
      addr2_in = addr2_ff;
      opcode_in = opcode_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      result_valid = 1'b0;
      result = '0;

      if (rx_byte == cfg.start_code) begin
         // start code wins anywhere, also mid-frame
         phase_in = PH_ADDR0;
         xor_in = '0;
         held_in = '0;
         held_valid_in = 1'b0;
         addr0_in = '0;
         addr1_in = '0;
         addr2_in = '0;
         opcode_in = '0;
         count_in = '0;
         ovf_in = 1'b0;
      end else if (phase_ff == PH_IDLE) begin
         phase_in = PH_IDLE;
      end else if (rx_byte == cfg.end_code) begin
         result_valid = 1'b1;
         result.out_kind = KIND_REPORT;
         result.addr_first = addr0_ff;
         result.addr_second = addr1_ff;
         result.addr_third = addr2_ff;
         result.frame_opcode = opcode_ff;
         result.payload_count = plain ? count_ff : '0;
         priority if (phase_ff != PH_DATA || !held_valid_ff) begin
            result.frame_status = STATUS_TOO_SHORT;
         end else if (held_ff != expected_sum) begin
            result.frame_status = STATUS_BAD_CHECKSUM;
         end else if (opcode_ff == cfg.secure_opcode) begin
            result.frame_status = STATUS_SECURE;
         end else if (ovf_ff) begin
            result.frame_status = STATUS_TOO_LONG;
         end else begin
            result.frame_status = STATUS_OK;
         end
         phase_in = PH_IDLE;
         xor_in = '0;
         held_in = '0;
         held_valid_in = 1'b0;
         addr0_in = '0;
         addr1_in = '0;
         addr2_in = '0;
         opcode_in = '0;
         count_in = '0;
         ovf_in = 1'b0;
      end else begin
         // the held byte is body; the new one waits in case it is the checksum
         if (held_valid_ff) begin
            xor_in = xor_ff ^ held_ff;
            unique case (phase_ff)
               PH_ADDR0: begin
                  addr0_in = held_ff[SevenWidth-1:0];
                  phase_in = PH_ADDR1;
               end
               PH_ADDR1: begin
                  addr1_in = held_ff[SevenWidth-1:0];
                  phase_in = PH_ADDR2;
               end
               PH_ADDR2: begin
                  addr2_in = held_ff[SevenWidth-1:0];
                  phase_in = PH_OPCODE;
               end
               PH_OPCODE: begin
                  opcode_in = held_ff;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (count_ff < CountLimit) begin
                     count_in = count_ff + 8'd1;
                     if (plain) begin
                        result_valid = 1'b1;
                        result.out_kind = KIND_DATA;
                        result.payload_byte = held_ff[SevenWidth-1:0];
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         held_in = rx_byte;
         held_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         xor_ff <= '0;
         held_ff <= '0;
         held_valid_ff <= 1'b0;
         addr0_ff <= '0;
         addr1_ff <= '0;
         addr2_ff <= '0;
         opcode_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         xor_ff <= xor_in;
         held_ff <= held_in;
         held_valid_ff <= held_valid_in;
         addr0_ff <= addr0_in;
         addr1_ff <= addr1_in;
         addr2_ff <= addr2_in;
         opcode_ff <= opcode_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

### rtl/sefd_outbuf.sv
module sefd_outbuf (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  sefd_pkg::result_type                result,
   output logic                                space,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sefd_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                rsp_tuser
);
   import sefd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // a new transaction may enter while the held one is taken this cycle
   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser = data_ff.out_kind;
   assign rsp_tdata = {1'b0, data_ff.frame_status, data_ff.payload_count,
                       data_ff.frame_opcode, data_ff.addr_third, data_ff.addr_second,
                       data_ff.addr_first, data_ff.payload_byte};

endmodule

### rtl/stx_etx_frame_deframer_top.sv
// A registered result appears on rsp the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle if not stalled; per byte: compare, XOR, register update.
// The result register lets a new byte in while the held result is taken the same cycle.
// Reset (synchronous, active high): frame state idle and cleared, result register
// empty, configuration registers back to their default codes.
module stx_etx_frame_deframer_top #(
   parameter int unsigned MAX_PAYLOAD = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sefd_pkg::ByteWidth-1:0]      req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] payload_byte, [13:7] addr_first, [20:14] addr_second, [27:21] addr_third,
   // [35:28] frame_opcode, [43:36] payload_count, [46:44] frame_status, [47] zero
   output logic [sefd_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                rsp_tuser,   // [0] out_kind
   input  logic                                csr_wr_en,
   input  logic [sefd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [sefd_pkg::ByteWidth-1:0]      csr_wdata
);
   import sefd_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       result_valid;
   logic       space;
   logic       take;

   assign req_tready = space;
   assign take = req_tvalid && space;

   sefd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sefd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .take         (take),
      .rx_byte      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   sefd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (take && result_valid),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
